### sv/nss_pkg.sv
package nss_pkg;

   // Sizing of the line buffer and the per-type sentence stores.
   localparam int LINE_LIMIT    = 200;
   localparam int STORE_DEPTH   = 256;
   localparam int KINDS         = 5;
   localparam int HDR_LEN       = 6;
   localparam int LB_DEPTH      = 256;
   localparam int LB_AW         = 8;
   localparam int LEN_W         = 8;
   localparam int STORE_ENTRIES = KINDS * STORE_DEPTH;
   localparam int STORE_AW      = $clog2(STORE_ENTRIES);

   // Access modes of an input item.
   localparam logic [1:0] MODE_RECEIVE = 2'd0;
   localparam logic [1:0] MODE_READ    = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   // Result events.
   localparam logic [2:0] EV_TAKEN      = 3'd0;
   localparam logic [2:0] EV_FILED      = 3'd1;
   localparam logic [2:0] EV_UNMATCHED  = 3'd2;
   localparam logic [2:0] EV_OVERFLOW   = 3'd3;
   localparam logic [2:0] EV_LINE_ERROR = 3'd4;
   localparam logic [2:0] EV_READ       = 3'd5;
   localparam logic [2:0] EV_CLEARED    = 3'd6;

   // Sentence types; the code after the last type means no type.
   localparam logic [2:0] KIND_NONE = 3'd5;

   localparam logic [7:0] LF_BYTE = 8'h0A;

   // Header of each sentence type, first character in the top byte.
   localparam logic [8*HDR_LEN-1:0] HEADER [KINDS] = '{
      "$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG"
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_imm;
      logic load_read;
      logic copy_run;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_read;
      logic files;
      logic copy_done;
   } status_type;

endpackage

### sv/nss_controller.sv
module nss_controller import nss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a result when empty or when being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = req_valid && (state_ff == ST_IDLE) && out_free;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if (status.needs_read) begin
                  state_in = ST_READ;
               end else begin
                  cmd.load_imm = 1'b1;
                  if (status.files) begin
                     state_in = ST_COPY;
                  end
               end
            end
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_COPY: begin
            cmd.copy_run = 1'b1;
            if (status.copy_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load_imm || cmd.load_read) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // State and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/nss_datapath.sv
module nss_datapath import nss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_line_error,
   input  logic [2:0]       req_read_kind,
   input  logic [7:0]       req_read_index,
   output logic [2:0]       rsp_event_res,
   output logic [2:0]       rsp_kind,
   output logic [LEN_W-1:0] rsp_length,
   output logic [7:0]       rsp_read_data
);

   // Memories.
   logic [7:0] line_buf_ff [LB_DEPTH];
   logic [7:0] store_ff [STORE_ENTRIES];

   // Line assembly state.
   logic [7:0]       hdr_ff [HDR_LEN];
   logic [7:0]       hdr_in [HDR_LEN];
   logic [LEN_W-1:0] wpos_ff, wpos_in;
   logic [LEN_W-1:0] slen_ff [KINDS];
   logic [LEN_W-1:0] slen_in [KINDS];

   // Copy sequencer.
   logic [2:0]       kind_ff, kind_in;
   logic [LEN_W-1:0] keep_ff, keep_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] wr_idx_ff, wr_idx_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [7:0]       lb_q_ff;
   logic [STORE_AW-1:0] wr_addr;

   // Read path.
   logic [7:0]       store_q_ff;
   logic [2:0]       rd_kind_ff, rd_kind_in;
   logic [LEN_W-1:0] rd_len_ff, rd_len_in;
   logic             rd_hit_ff, rd_hit_in;
   logic             kind_ok, hit;
   logic [LEN_W-1:0] sel_len;
   logic [STORE_AW-1:0] rd_addr;

   // Output register.
   logic [2:0]       ev_ff, rkind_ff;
   logic [LEN_W-1:0] rlen_ff;
   logic [7:0]       rdata_ff;

   // Decode of the incoming item.
   logic [8*HDR_LEN-1:0] hdr_word;
   logic [2:0]       match_kind;
   logic             is_lf, overflow, has_hdr, files, is_rx;
   logic [LEN_W-1:0] size, keep;
   logic [2:0]       imm_ev, imm_kind;
   logic [LEN_W-1:0] imm_len;

   // Header comparison over the captured first six bytes.
   always_comb begin
      for (int j = 0; j < HDR_LEN; j++) begin
         hdr_word[8*(HDR_LEN-1-j) +: 8] = hdr_ff[j];
      end
      match_kind = KIND_NONE;
      for (int k = KINDS - 1; k >= 0; k--) begin
         if (hdr_word == HEADER[k]) begin
            match_kind = 3'(k);
         end
      end
   end

   // Classification of a received byte. A line of exactly six bytes ends in
   // the line feed at header position, so only longer lines can match.
   assign is_rx    = (req_mode == MODE_RECEIVE) && !req_line_error;
   assign is_lf    = (req_rx_byte == LF_BYTE);
   assign overflow = (wpos_ff >= LEN_W'(LINE_LIMIT));
   assign has_hdr  = (wpos_ff >= LEN_W'(HDR_LEN));
   assign size     = wpos_ff + 1'b1;
   assign keep     = ({1'b0, size} < 9'(STORE_DEPTH)) ? size : LEN_W'(STORE_DEPTH);
   assign files    = is_rx && !overflow && is_lf && has_hdr && (match_kind != KIND_NONE);

   // Selection of a stored byte for a read access.
   assign kind_ok = (req_read_kind < 3'(KINDS));
   assign sel_len = kind_ok ? slen_ff[req_read_kind] : '0;
   assign hit     = (req_read_index < sel_len);
   assign rd_addr = hit ? (STORE_AW'(req_read_kind) * STORE_AW'(STORE_DEPTH)
                           + STORE_AW'(req_read_index)) : '0;
   assign wr_addr = STORE_AW'(kind_ff) * STORE_AW'(STORE_DEPTH) + STORE_AW'(wr_idx_ff);

   // Result of items answered at once.
   always_comb begin
      imm_ev   = EV_READ;
      imm_kind = KIND_NONE;
      imm_len  = '0;
      case (req_mode)
         MODE_RECEIVE: begin
            if (req_line_error) begin
               imm_ev = EV_LINE_ERROR;
            end else if (overflow) begin
               imm_ev = EV_OVERFLOW;
            end else if (!is_lf) begin
               imm_ev = EV_TAKEN;
            end else if (files) begin
               imm_ev   = EV_FILED;
               imm_kind = match_kind;
               imm_len  = size;
            end else begin
               imm_ev = EV_UNMATCHED;
            end
         end
         MODE_CLEAR: begin
            imm_ev = EV_CLEARED;
         end
         default: begin
            imm_ev = EV_READ;
         end
      endcase
   end

   assign status.needs_read = (req_mode == MODE_READ) && kind_ok;
   assign status.files      = files;
   assign status.copy_done  = wr_pend_ff && (rd_idx_ff == keep_ff);

   // Next values of the line, length and sequencer state.
   always_comb begin
      wpos_in    = wpos_ff;
      hdr_in     = hdr_ff;
      slen_in    = slen_ff;
      kind_in    = kind_ff;
      keep_in    = keep_ff;
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      wr_pend_in = 1'b0;
      rd_kind_in = rd_kind_ff;
      rd_len_in  = rd_len_ff;
      rd_hit_in  = rd_hit_ff;
      if (cmd.accept) begin
         case (req_mode)
            MODE_RECEIVE: begin
               if (req_line_error || overflow) begin
                  wpos_in = '0;
               end else begin
                  for (int j = 0; j < HDR_LEN; j++) begin
                     if (wpos_ff == LEN_W'(j)) begin
                        hdr_in[j] = req_rx_byte;
                     end
                  end
                  wpos_in = is_lf ? '0 : size;
               end
               if (files) begin
                  for (int k = 0; k < KINDS; k++) begin
                     if (match_kind == 3'(k)) begin
                        slen_in[k] = keep;
                     end
                  end
                  kind_in   = match_kind;
                  keep_in   = keep;
                  rd_idx_in = '0;
               end
            end
            MODE_READ: begin
               rd_kind_in = req_read_kind;
               rd_len_in  = sel_len;
               rd_hit_in  = hit;
            end
            MODE_CLEAR: begin
               for (int k = 0; k < KINDS; k++) begin
                  slen_in[k] = '0;
               end
            end
            default: begin
               wpos_in = wpos_ff;
            end
         endcase
      end
      // One line buffer byte is fetched per cycle and written to the store in the following cycle.
      if (cmd.copy_run && (rd_idx_ff != keep_ff)) begin
         rd_idx_in  = rd_idx_ff + 1'b1;
         wr_idx_in  = rd_idx_ff;
         wr_pend_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff    <= '0;
         wr_pend_ff <= 1'b0;
         for (int k = 0; k < KINDS; k++) begin
            slen_ff[k] <= '0;
         end
      end else begin
         wpos_ff    <= wpos_in;
         wr_pend_ff <= wr_pend_in;
         slen_ff    <= slen_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hdr_ff     <= hdr_in;
      kind_ff    <= kind_in;
      keep_ff    <= keep_in;
      rd_idx_ff  <= rd_idx_in;
      wr_idx_ff  <= wr_idx_in;
      rd_kind_ff <= rd_kind_in;
      rd_len_ff  <= rd_len_in;
      rd_hit_ff  <= rd_hit_in;
   end

   // Line buffer: written by received bytes, read by the copy sequencer.
   always_ff @(posedge clock) begin
      if (cmd.accept && is_rx && !overflow) begin
         line_buf_ff[wpos_ff[LB_AW-1:0]] <= req_rx_byte;
      end
      lb_q_ff <= line_buf_ff[rd_idx_ff[LB_AW-1:0]];
   end

   // Sentence store: written by the copy sequencer, read by read accesses.
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         store_ff[wr_addr] <= lb_q_ff;
      end
      store_q_ff <= store_ff[rd_addr];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_imm) begin
         ev_ff    <= imm_ev;
         rkind_ff <= imm_kind;
         rlen_ff  <= imm_len;
         rdata_ff <= '0;
      end else if (cmd.load_read) begin
         ev_ff    <= EV_READ;
         rkind_ff <= rd_kind_ff;
         rlen_ff  <= rd_len_ff;
         rdata_ff <= rd_hit_ff ? store_q_ff : '0;
      end
   end

   assign rsp_event_res = ev_ff;
   assign rsp_kind      = rkind_ff;
   assign rsp_length    = rlen_ff;
   assign rsp_read_data = rdata_ff;

endmodule

### sv/nmea_sentence_sorter.sv
// Receiver and sorter for NMEA 0183 sentences. Each request is one received
// byte, one byte read from a stored sentence, or a clear of all stored
// lengths, and each gives exactly one response through an output register.
// Received bytes, clears and reads of an unknown type are answered at once; a
// read of a valid type waits in a read state for the registered read of the
// sentence store. A line feed that files a sentence answers at once, then the
// block stalls requests while the line (its length capped at the store depth)
// is copied a byte a cycle from the line buffer read port to the sentence
// store write port. No clearing pass follows reset: stored lengths reset to
// zero at once.
module nmea_sentence_sorter import nss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_rx_byte,
   input  logic       req_line_error,
   input  logic [2:0] req_read_kind,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_length,
   output logic [7:0] rsp_read_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of transfers, reads and copies.
   nss_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Line buffer, stores and output register.
   nss_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_rx_byte    (req_rx_byte),
      .req_line_error (req_line_error),
      .req_read_kind  (req_read_kind),
      .req_read_index (req_read_index),
      .rsp_event_res  (rsp_event_res),
      .rsp_kind       (rsp_kind),
      .rsp_length     (rsp_length),
      .rsp_read_data  (rsp_read_data)
   );

   // A response held by the consumer blocks further requests.
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a response is held");

   // Filing a sentence starts a copy that blocks the next request.
   a_copy_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.files |=> req_stall && cmd.copy_run)
      else $error("copy did not follow a filed sentence");

   // Read data is loaded only in the cycle after a read was accepted.
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_read |-> $past(cmd.accept && status.needs_read))
      else $error("read data loaded without a read access");

endmodule

### tb/nmea_sentence_sorter_tb.sv
module nmea_sentence_sorter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nss_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 950;
   localparam int DRAIN_CYCLES = 220;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 450;
   localparam int PAUSE_AT     = 700;
   localparam int MAX_PRINTS   = 40;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] KIND_GGA = 3'd0;
   localparam logic [2:0] KIND_VTG = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
      logic       line_error;
      logic [2:0] read_kind;
      logic [7:0] read_index;
   } nmea_req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [2:0] kind;
      logic [7:0] length;
      logic [7:0] read_data;
   } nmea_rsp_type;

   typedef struct packed {
      nmea_req_type req;
      logic         typed;
      nmea_rsp_type want;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_mode;
   logic [7:0] req_rx_byte;
   logic       req_line_error;
   logic [2:0] req_read_kind;
   logic [7:0] req_read_index;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_event_res;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_length;
   logic [7:0] rsp_read_data;

   // Predicted copy of the line buffer, the filed sentences and their lengths.
   logic [7:0] line_copy [LB_DEPTH];
   int         line_fill;
   logic [7:0] filed_bytes [KINDS][STORE_DEPTH];
   int         filed_len [KINDS];

   nmea_rsp_type rsp_expected [$];
   int           items_in = 0;
   int           rsp_count = 0;
   int           errors = 0;
   int           cycles = 0;
   int           holds_asked = 0;
   int           ev_seen [8] = '{default: 0};
   bit           calm = 1'b0;

   nmea_sentence_sorter u_dut (.*);

   // Free-running clock.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Works out the response to one accepted request and updates the copied state.
   function automatic nmea_rsp_type predict_response(nmea_req_type it);
      nmea_rsp_type r;
      int           size;
      int           keep;
      int           hit;
      bit           same;
      r.event_res = EV_READ;
      r.kind      = KIND_NONE;
      r.length    = '0;
      r.read_data = '0;
      case (it.mode)
         MODE_RECEIVE: begin
            if (it.line_error) begin
               line_fill   = 0;
               r.event_res = EV_LINE_ERROR;
            end else if (line_fill >= LINE_LIMIT) begin
               // A full buffer drops the byte, even a line feed, and restarts the line.
               line_fill   = 0;
               r.event_res = EV_OVERFLOW;
            end else begin
               line_copy[line_fill] = it.rx_byte;
               line_fill++;
               if (it.rx_byte != LF_BYTE) begin
                  r.event_res = EV_TAKEN;
               end else begin
                  size      = line_fill;
                  line_fill = 0;
                  hit       = KINDS;
                  // Lines shorter than a header never match.
                  if (size >= HDR_LEN) begin
                     for (int k = 0; k < KINDS; k++) begin
                        same = 1'b1;
                        for (int i = 0; i < HDR_LEN; i++) begin
                           if (line_copy[i] != HEADER[k][8*(HDR_LEN-1-i) +: 8]) same = 1'b0;
                        end
                        if (same && hit == KINDS) hit = k;
                     end
                  end
                  if (hit == KINDS) begin
                     r.event_res = EV_UNMATCHED;
                  end else begin
                     keep = (size < STORE_DEPTH) ? size : STORE_DEPTH;
                     for (int i = 0; i < keep; i++) filed_bytes[hit][i] = line_copy[i];
                     filed_len[hit] = keep;
                     r.event_res    = EV_FILED;
                     r.kind         = 3'(hit);
                     r.length       = 8'(size);
                  end
               end
            end
         end
         MODE_READ: begin
            if (it.read_kind < KINDS) begin
               r.kind   = it.read_kind;
               r.length = 8'(filed_len[it.read_kind]);
               if (it.read_index < filed_len[it.read_kind] && it.read_index < STORE_DEPTH)
                  r.read_data = filed_bytes[it.read_kind][it.read_index];
            end
         end
         MODE_CLEAR: begin
            for (int k = 0; k < KINDS; k++) filed_len[k] = 0;
            r.event_res = EV_CLEARED;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic nmea_req_type mk_req(logic [1:0] mode, logic [7:0] rx, logic err,
                                           logic [2:0] rk, logic [7:0] ri);
      nmea_req_type it;
      it.mode       = mode;
      it.rx_byte    = rx;
      it.line_error = err;
      it.read_kind  = rk;
      it.read_index = ri;
      return it;
   endfunction

   function automatic nmea_rsp_type rsp(logic [2:0] ev, logic [2:0] kind, logic [7:0] len,
                                        logic [7:0] data);
      nmea_rsp_type r;
      r.event_res = ev;
      r.kind      = kind;
      r.length    = len;
      r.read_data = data;
      return r;
   endfunction

   function automatic dir_row_type row(nmea_req_type it, logic typed, nmea_rsp_type want);
      dir_row_type d;
      d.req   = it;
      d.typed = typed;
      d.want  = want;
      return d;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == LF_BYTE) b = 8'h2C;
      return b;
   endfunction

   function automatic int body_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 16);
   endfunction

   // Offers one request, holds it until the transfer and records the expected response.
   task automatic push_item(nmea_req_type it, logic typed = 1'b0, nmea_rsp_type want = '0);
      int           gap;
      nmea_rsp_type pred;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= it.mode;
      req_rx_byte    <= it.rx_byte;
      req_line_error <= it.line_error;
      req_read_kind  <= it.read_kind;
      req_read_index <= it.read_index;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pred = predict_response(it);
      rsp_expected.push_back(typed ? want : pred);
      items_in++;
      @(negedge clock);
   endtask

   // Received byte; the read fields are ignored in this mode, so they carry noise.
   task automatic send_rx(logic [7:0] b, logic err);
      push_item(mk_req(MODE_RECEIVE, b, err, 3'($urandom), 8'($urandom)));
   endtask

   // A full sentence: header, body and line feed, optionally with a spoilt header
   // byte or a line error at one position.
   task automatic send_sentence(int kind, int blen, bit near_miss, int err_at);
      logic [7:0] b;
      int         spoil;
      spoil = near_miss ? $urandom_range(0, HDR_LEN - 1) : -1;
      for (int i = 0; i < HDR_LEN; i++) begin
         b = HEADER[kind][8*(HDR_LEN-1-i) +: 8];
         if (i == spoil) b = b ^ 8'($urandom_range(1, 255));
         send_rx(b, i == err_at);
      end
      for (int i = 0; i < blen; i++) send_rx(body_byte(), (i + HDR_LEN) == err_at);
      send_rx(LF_BYTE, 1'b0);
   endtask

   // Read of a stored byte, mostly within the stored length of a valid type.
   task automatic send_read();
      int rk;
      int ri;
      rk = ($urandom_range(0, 9) < 8) ? $urandom_range(0, KINDS - 1) : $urandom_range(5, 7);
      if (rk < KINDS && filed_len[rk] > 0 && $urandom_range(0, 9) < 7)
         ri = $urandom_range(0, filed_len[rk] - 1);
      else
         ri = $urandom_range(0, 255);
      push_item(mk_req(MODE_READ, 8'($urandom), 1'($urandom), 3'(rk), 8'(ri)));
   endtask

   // Sender stops offering until every expected response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rsp_expected.size() != 0) @(negedge clock);
   endtask

   task automatic report_mismatch(string what, int got, int want_v);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("%0t: response %0d, %s: got %0d, expected %0d",
                  $time, rsp_count, what, got, want_v);
   endtask

   // Receiver stall: random gaps, and a long hold-off whenever one is asked for.
   initial begin : receiver_stall
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            stall_left = HOLD_CYCLES;
            holds_done++;
         end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
            stall_left = idle_len();
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Each response transfer is checked against the oldest expectation.
   always @(posedge clock) begin : response_check
      nmea_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected.size() == 0) begin
            report_mismatch("response with nothing expected, event", rsp_event_res, -1);
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_event_res !== want.event_res)
               report_mismatch("event", rsp_event_res, want.event_res);
            if (rsp_kind !== want.kind)
               report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_length !== want.length)
               report_mismatch("length", rsp_length, want.length);
            if (rsp_read_data !== want.read_data)
               report_mismatch("read data", rsp_read_data, want.read_data);
         end
         ev_seen[rsp_event_res]++;
         rsp_count++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("nmea_sentence_sorter test failed");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows [$];
      int          random_start;
      int          r;
      int          n;
      bit          held;
      bit          paused;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_RECEIVE;
      req_rx_byte    = '0;
      req_line_error = 1'b0;
      req_read_kind  = '0;
      req_read_index = '0;
      line_fill      = 0;
      for (int k = 0; k < KINDS; k++) filed_len[k] = 0;
      held   = 1'b0;
      paused = 1'b0;

      // Directed rows: empty stores after reset, unknown types, the unused mode, line
      // errors, a short line, a minimal filed sentence and its read-back, and clears.
      dir_rows.push_back(row(mk_req(MODE_READ, 8'h00, 1'b0, KIND_GGA, 8'd0), 1'b1,
                             rsp(EV_READ, KIND_GGA, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_READ, 8'hFF, 1'b1, KIND_VTG, 8'd255), 1'b1,
                             rsp(EV_READ, KIND_VTG, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_READ, 8'h00, 1'b0, 3'd7, 8'd0), 1'b1,
                             rsp(EV_READ, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_UNUSED, 8'hFF, 1'b1, 3'd7, 8'd255), 1'b1,
                             rsp(EV_READ, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_CLEAR, 8'hFF, 1'b1, 3'd7, 8'd255), 1'b1,
                             rsp(EV_CLEARED, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_RECEIVE, 8'hFF, 1'b1, 3'd0, 8'd0), 1'b1,
                             rsp(EV_LINE_ERROR, KIND_NONE, 8'd0, 8'd0)));
      for (int i = 0; i < 3; i++)
         dir_rows.push_back(row(mk_req(MODE_RECEIVE, HEADER[KIND_GGA][8*(HDR_LEN-1-i) +: 8],
                                       1'b0, 3'd0, 8'd0), 1'b1,
                                rsp(EV_TAKEN, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_RECEIVE, LF_BYTE, 1'b0, 3'd0, 8'd0), 1'b1,
                             rsp(EV_UNMATCHED, KIND_NONE, 8'd0, 8'd0)));
      for (int i = 0; i < HDR_LEN; i++)
         dir_rows.push_back(row(mk_req(MODE_RECEIVE, HEADER[KIND_VTG][8*(HDR_LEN-1-i) +: 8],
                                       1'b0, 3'd0, 8'd0), 1'b1,
                                rsp(EV_TAKEN, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_RECEIVE, LF_BYTE, 1'b0, 3'd0, 8'd0), 1'b0, '0));
      dir_rows.push_back(row(mk_req(MODE_READ, 8'h00, 1'b0, KIND_VTG, 8'd0), 1'b0, '0));
      dir_rows.push_back(row(mk_req(MODE_READ, 8'h00, 1'b0, KIND_VTG, 8'd6), 1'b0, '0));
      dir_rows.push_back(row(mk_req(MODE_READ, 8'h00, 1'b0, KIND_VTG, 8'd7), 1'b0, '0));
      dir_rows.push_back(row(mk_req(MODE_RECEIVE, 8'h00, 1'b0, 3'd0, 8'd0), 1'b1,
                             rsp(EV_TAKEN, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_RECEIVE, LF_BYTE, 1'b1, 3'd0, 8'd0), 1'b1,
                             rsp(EV_LINE_ERROR, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_CLEAR, 8'h00, 1'b0, 3'd0, 8'd0), 1'b1,
                             rsp(EV_CLEARED, KIND_NONE, 8'd0, 8'd0)));
      dir_rows.push_back(row(mk_req(MODE_READ, 8'h00, 1'b0, KIND_VTG, 8'd0), 1'b1,
                             rsp(EV_READ, KIND_VTG, 8'd0, 8'd0)));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) push_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      wait_drained();

      // Longest sentence that still fits, then a line that overflows on its line feed.
      random_start = items_in;
      send_sentence($urandom_range(0, KINDS - 1), LINE_LIMIT - HDR_LEN - 1, 1'b0, -1);
      for (int i = 0; i < LINE_LIMIT; i++) send_rx(body_byte(), 1'b0);
      send_rx(LF_BYTE, 1'b0);

      // Random part: mostly well-formed sentences and read-backs, with noise mixed in.
      while (items_in - random_start < RANDOM_ITEMS) begin
         if (!held && items_in - random_start >= HOLD_AT) begin
            held = 1'b1;
            holds_asked++;
         end
         if (!paused && items_in - random_start >= PAUSE_AT) begin
            paused = 1'b1;
            wait_drained();
         end
         calm = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 50) begin
            send_sentence($urandom_range(0, KINDS - 1), body_len(), 1'b0, -1);
         end else if (r < 58) begin
            send_sentence($urandom_range(0, KINDS - 1), body_len(), 1'b1, -1);
         end else if (r < 63) begin
            send_sentence($urandom_range(0, KINDS - 1), body_len(), 1'b0,
                          $urandom_range(0, 8));
         end else if (r < 66) begin
            // Short line: part of a header and then the line feed.
            n = $urandom_range(0, HDR_LEN - 1);
            for (int i = 0; i < n; i++)
               send_rx(HEADER[$urandom_range(0, KINDS - 1)][8*(HDR_LEN-1-i) +: 8], 1'b0);
            send_rx(LF_BYTE, 1'b0);
         end else if (r < 86) begin
            repeat ($urandom_range(1, 4)) send_read();
         end else if (r < 89) begin
            push_item(mk_req(MODE_CLEAR, 8'($urandom), 1'($urandom), 3'($urandom),
                             8'($urandom)));
         end else begin
            push_item(mk_req(2'($urandom), 8'($urandom), 1'($urandom), 3'($urandom),
                             8'($urandom)));
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d request and %0d response transfers, with a receiver hold-off.",
               items_in, rsp_count);
      $display("%0d filed, %0d unmatched, %0d overflow, %0d line error, %0d read, %0d clear.",
               ev_seen[EV_FILED], ev_seen[EV_UNMATCHED], ev_seen[EV_OVERFLOW],
               ev_seen[EV_LINE_ERROR], ev_seen[EV_READ], ev_seen[EV_CLEARED]);
      if (errors == 0) begin
         $display("nmea_sentence_sorter test passed");
      end else begin
         $display("nmea_sentence_sorter test failed");
      end
      $finish;
   end

endmodule
